FILE: src/lsdf_pkg.sv
// ----------------------------------------------------------------------------
// lsdf_pkg
// Types and constants shared by the light switch debounce and flasher core.
// ----------------------------------------------------------------------------
package lsdf_pkg;

    localparam int unsigned CountWidth = 4;
    localparam int unsigned BlinkWidth = 8;
    localparam int unsigned CfgIdxWidth = 3;
    localparam int unsigned CfgDataWidth = 8;

    // configuration register indexes
    localparam logic [CfgIdxWidth-1:0] REG_HEAD_DEBOUNCE = 3'd0;
    localparam logic [CfgIdxWidth-1:0] REG_DEBOUNCE      = 3'd1;
    localparam logic [CfgIdxWidth-1:0] REG_HEAD_LOCKOUT  = 3'd2;
    localparam logic [CfgIdxWidth-1:0] REG_BLINK_PERIOD  = 3'd3;
    localparam logic [CfgIdxWidth-1:0] REG_BLINK_HALF    = 3'd4;

    // configuration reset values
    localparam logic [CountWidth-1:0] HEAD_DEBOUNCE_RST = 4'd3;
    localparam logic [CountWidth-1:0] DEBOUNCE_RST      = 4'd10;
    localparam logic [BlinkWidth-1:0] HEAD_LOCKOUT_RST  = 8'd200;
    localparam logic [BlinkWidth-1:0] BLINK_PERIOD_RST  = 8'd100;
    localparam logic [BlinkWidth-1:0] BLINK_HALF_RST    = 8'd50;

    typedef struct packed {
        logic head_switch;
        logic fog_switch;
        logic top_switch;
        logic hazard_switch;
        logic left_switch_n;
        logic right_switch_n;
    } lsdf_in_t;

    typedef struct packed {
        logic top_light;
        logic fog_light;
        logic head_light;
        logic left_lamp_n;
        logic right_lamp_n;
    } lsdf_out_t;

    // per-tick controls from the top level into one flasher
    typedef struct packed {
        logic tick_en;
        logic haz_load;
        logic pressed;
        logic held_set;
    } lsdf_flash_ctl_t;

endpackage

FILE: src/lsdf_debounce.sv
// ----------------------------------------------------------------------------
// lsdf_debounce
// Stable-count debouncer for one switch; pulses once when the count is hit.
// ----------------------------------------------------------------------------
module lsdf_debounce
    import lsdf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  tick_en,
    input  logic                  pressed,
    input  logic [CountWidth-1:0] ticks,
    output logic                  pulse
);

    logic [CountWidth-1:0] count_reg;
    logic [CountWidth-1:0] count_next;
    logic [CountWidth-1:0] count_inc;

    assign count_inc = count_reg + CountWidth'(1);

    always_comb begin
        count_next = count_reg;
        pulse      = 1'b0;
        if (!pressed) begin
            count_next = '0;
        end else if (count_reg < ticks) begin
            count_next = count_inc;
            pulse      = (count_inc >= ticks);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (tick_en) begin
            count_reg <= count_next;
        end
    end

endmodule

FILE: src/lsdf_flasher.sv
// ----------------------------------------------------------------------------
// lsdf_flasher
// One turn signal channel: blink counter, held flag and flasher pin.
// ----------------------------------------------------------------------------
module lsdf_flasher
    import lsdf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  lsdf_flash_ctl_t       ctl,
    input  logic [BlinkWidth-1:0] period,
    input  logic [BlinkWidth-1:0] half,
    output logic [BlinkWidth-1:0] count,
    output logic                  pin_next
);

    logic [BlinkWidth-1:0] count_reg;
    logic [BlinkWidth-1:0] count_next;
    logic [BlinkWidth-1:0] count_ld;
    logic [BlinkWidth-1:0] count_dec;
    logic                  pin_reg;
    logic                  held_reg;
    logic                  held_next;

    always_comb begin
        count_ld = ctl.haz_load ? period : count_reg;

        pin_next = pin_reg;
        if (count_ld == period) begin
            pin_next = 1'b0;
        end
        if (count_ld == half || count_ld == '0) begin
            pin_next = 1'b1;
        end

        count_dec = (count_ld != '0) ? count_ld - BlinkWidth'(1) : count_ld;

        held_next = held_reg;
        if (ctl.held_set) begin
            held_next = 1'b1;
        end
        if (!ctl.pressed) begin
            held_next = 1'b0;
        end

        count_next = (held_next && count_dec == '0) ? period : count_dec;
    end

    assign count = count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            pin_reg   <= 1'b0;
            held_reg  <= 1'b0;
        end else if (ctl.tick_en) begin
            count_reg <= count_next;
            pin_reg   <= pin_next;
            held_reg  <= held_next;
        end
    end

endmodule

FILE: src/light_switch_debounce_and_flasher_core.sv
// ----------------------------------------------------------------------------
// light_switch_debounce_and_flasher_core
// Debounces six light switches per tick and drives lights and flasher pins.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one request per 100 Hz tick with the six raw
//   switch levels. m_valid/m_ready/m_data return one result per request with
//   the top, fog and head drives and both flasher pins.
//   A request is processed in the cycle it is accepted; its result sits in the
//   output register in the next cycle. One request per cycle is accepted as
//   long as the output register is empty or being drained.
//   If the receiver stalls, the result holds in the output register and
//   s_ready drops until it is taken; no state advances meanwhile.
//   cfg_we/cfg_index/cfg_data write one of the five timing registers per write;
//   write them only while no request is in flight. Indexes above 4 are
//   ignored.
//   Reset (aresetn low, synchronous) restores default timing, turns all
//   lights off, clears the debounce and blink counters and empties the
//   output register.
// ----------------------------------------------------------------------------
module light_switch_debounce_and_flasher_core
    import lsdf_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  lsdf_in_t                s_data,
    output logic                    m_valid,
    input  logic                    m_ready,
    output lsdf_out_t               m_data,
    input  logic                    cfg_we,
    input  logic [CfgIdxWidth-1:0]  cfg_index,
    input  logic [CfgDataWidth-1:0] cfg_data
);

    // configuration
    logic [CountWidth-1:0] head_debounce_reg;
    logic [CountWidth-1:0] debounce_reg;
    logic [BlinkWidth-1:0] head_lockout_ticks_reg;
    logic [BlinkWidth-1:0] blink_period_reg;
    logic [BlinkWidth-1:0] blink_half_reg;

    // state
    logic [CountWidth-1:0] head_count_reg;
    logic [CountWidth-1:0] head_count_next;
    logic [CountWidth-1:0] head_count_inc;
    logic [BlinkWidth-1:0] head_lockout_reg;
    logic [BlinkWidth-1:0] head_lockout_next;
    logic                  top_flag_reg;
    logic                  fog_flag_reg;
    logic                  head_flag_reg;
    logic                  haz_flag_reg;

    logic                  m_valid_reg;
    lsdf_out_t             m_data_reg;

    logic                  in_accept;
    logic                  head_pulse;
    logic                  fog_pulse;
    logic                  top_pulse;
    logic                  haz_pulse;
    logic                  left_pulse;
    logic                  right_pulse;
    logic                  haz_load;
    logic [BlinkWidth-1:0] left_count;
    logic [BlinkWidth-1:0] right_count;
    logic                  left_pin;
    logic                  right_pin;
    lsdf_flash_ctl_t       left_ctl;
    lsdf_flash_ctl_t       right_ctl;

    assign s_ready   = !m_valid_reg || m_ready;
    assign in_accept = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_debounce_reg      <= HEAD_DEBOUNCE_RST;
            debounce_reg           <= DEBOUNCE_RST;
            head_lockout_ticks_reg <= HEAD_LOCKOUT_RST;
            blink_period_reg       <= BLINK_PERIOD_RST;
            blink_half_reg         <= BLINK_HALF_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_HEAD_DEBOUNCE: head_debounce_reg      <= cfg_data[CountWidth-1:0];
                REG_DEBOUNCE:      debounce_reg           <= cfg_data[CountWidth-1:0];
                REG_HEAD_LOCKOUT:  head_lockout_ticks_reg <= cfg_data[BlinkWidth-1:0];
                REG_BLINK_PERIOD:  blink_period_reg       <= cfg_data[BlinkWidth-1:0];
                REG_BLINK_HALF:    blink_half_reg         <= cfg_data[BlinkWidth-1:0];
                default: ;
            endcase
        end
    end

    // head switch with release-counted lockout
    assign head_count_inc = head_count_reg + CountWidth'(1);

    always_comb begin
        head_count_next   = head_count_reg;
        head_lockout_next = head_lockout_reg;
        head_pulse        = 1'b0;
        if (s_data.head_switch) begin
            if (head_lockout_reg == '0 && head_count_reg < head_debounce_reg) begin
                head_count_next = head_count_inc;
                if (head_count_inc >= head_debounce_reg) begin
                    head_pulse        = 1'b1;
                    head_lockout_next = head_lockout_ticks_reg;
                end
            end
        end else begin
            head_count_next = '0;
            if (head_lockout_reg != '0) begin
                head_lockout_next = head_lockout_reg - BlinkWidth'(1);
            end
        end
    end

    lsdf_debounce u_fog_db (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tick_en (in_accept),
        .pressed (s_data.fog_switch),
        .ticks   (debounce_reg),
        .pulse   (fog_pulse)
    );

    lsdf_debounce u_top_db (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tick_en (in_accept),
        .pressed (s_data.top_switch),
        .ticks   (debounce_reg),
        .pulse   (top_pulse)
    );

    lsdf_debounce u_haz_db (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tick_en (in_accept),
        .pressed (s_data.hazard_switch),
        .ticks   (debounce_reg),
        .pulse   (haz_pulse)
    );

    lsdf_debounce u_left_db (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tick_en (in_accept),
        .pressed (!s_data.left_switch_n),
        .ticks   (debounce_reg),
        .pulse   (left_pulse)
    );

    lsdf_debounce u_right_db (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tick_en (in_accept),
        .pressed (!s_data.right_switch_n),
        .ticks   (debounce_reg),
        .pulse   (right_pulse)
    );

    // hazard reloads both flashers only when both are idle
    assign haz_load = haz_flag_reg && left_count == '0 && right_count == '0;

    assign left_ctl  = '{tick_en: in_accept, haz_load: haz_load,
                         pressed: !s_data.left_switch_n, held_set: left_pulse};
    assign right_ctl = '{tick_en: in_accept, haz_load: haz_load,
                         pressed: !s_data.right_switch_n, held_set: right_pulse};

    lsdf_flasher u_left_fl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (left_ctl),
        .period   (blink_period_reg),
        .half     (blink_half_reg),
        .count    (left_count),
        .pin_next (left_pin)
    );

    lsdf_flasher u_right_fl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (right_ctl),
        .period   (blink_period_reg),
        .half     (blink_half_reg),
        .count    (right_count),
        .pin_next (right_pin)
    );

    // state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_count_reg   <= '0;
            head_lockout_reg <= '0;
            top_flag_reg     <= 1'b0;
            fog_flag_reg     <= 1'b0;
            head_flag_reg    <= 1'b0;
            haz_flag_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (in_accept) begin
                head_count_reg   <= head_count_next;
                head_lockout_reg <= head_lockout_next;
                top_flag_reg     <= top_flag_reg ^ top_pulse;
                fog_flag_reg     <= fog_flag_reg ^ fog_pulse;
                head_flag_reg    <= head_flag_reg ^ head_pulse;
                haz_flag_reg     <= haz_flag_reg ^ haz_pulse;
                m_valid_reg      <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg      <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            m_data_reg <= '{top_light: top_flag_reg, fog_light: fog_flag_reg,
                            head_light: head_flag_reg, left_lamp_n: left_pin,
                            right_lamp_n: right_pin};
        end
    end

    // checks
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> m_valid_reg)
        else $error("result missing after accepted request");

    a_flags_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_accept |=> $stable({top_flag_reg, fog_flag_reg, head_flag_reg, haz_flag_reg}))
        else $error("light flags changed without a request");

    a_lockout_load: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept && head_pulse |=> head_lockout_reg == $past(head_lockout_ticks_reg))
        else $error("head lockout not loaded on toggle");

    a_head_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_accept |=> $stable(head_count_reg) && $stable(head_lockout_reg))
        else $error("head debounce state moved without a request");

endmodule
